@@ hdl/swm_pkg.sv @@
// swm_pkg: shared constants, types and helpers for the sliding window maximum
// used by every module in hdl; depends on nothing else

package swm_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int SAMPLE_W   = 32;
  localparam int CFG_W      = 7;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int LO_W       = IDX_W / 2;
  localparam int HI_W       = IDX_W - LO_W;
  localparam int GROUPS     = 2 ** HI_W;
  localparam int PAD_LEN    = 2 ** IDX_W;

  localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } swm_sel_t;

  // a size of zero acts as one, anything above the cell count acts as the cell count
  function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] ws);
    logic [CNT_W-1:0] k;
    if (ws == '0) begin
      k = CNT_W'(1);
    end else if (int'(ws) > WINDOW_MAX) begin
      k = CNT_W'(WINDOW_MAX);
    end else begin
      k = CNT_W'(ws);
    end
    return k;
  endfunction

endpackage

@@ hdl/swm_cell.sv @@
// swm_cell: one cell of the running maximum chain, holds the maximum over
// the newest samples up to its own age; depends on swm_pkg

module swm_cell (
  input  logic              clk,
  input  logic              en,
  input  logic              restart,
  input  swm_pkg::sample_t  sample,
  input  swm_pkg::sample_t  prev,
  output swm_pkg::sample_t  value
);

  swm_pkg::sample_t value_next;

  always_comb begin
    if (restart || (sample > prev)) begin
      value_next = sample;
    end else begin
      value_next = prev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
    end
  end

endmodule

@@ hdl/swm_select.sv @@
// swm_select: two-stage registered selection of one cell of the chain,
// ending in the output register; depends on swm_pkg

module swm_select (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  swm_pkg::swm_sel_t  sel,
  input  swm_pkg::sample_t   cells [swm_pkg::WINDOW_MAX],
  output logic               out_valid,
  output swm_pkg::sample_t   out_data
);

  swm_pkg::sample_t               cells_pad [swm_pkg::PAD_LEN];
  swm_pkg::sample_t               grp [swm_pkg::GROUPS];
  logic [swm_pkg::HI_W-1:0]       hi1;
  logic                           v1;

  for (genvar i = 0; i < swm_pkg::PAD_LEN; i++) begin : g_pad
    if (i < swm_pkg::WINDOW_MAX) begin : g_cell
      assign cells_pad[i] = cells[i];
    end else begin : g_zero
      assign cells_pad[i] = '0;
    end
  end

  // first stage: one entry out of each group
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= sel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hi1 <= sel.idx[swm_pkg::IDX_W-1:swm_pkg::LO_W];
      for (int g = 0; g < swm_pkg::GROUPS; g++) begin
        grp[g] <= cells_pad[{swm_pkg::HI_W'(g), sel.idx[swm_pkg::LO_W-1:0]}];
      end
    end
  end

  // second stage: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= grp[hi1];
    end
  end

endmodule

@@ hdl/sliding_window_maximum.sv @@
// sliding_window_maximum: top level, window counters, cell chain and selection
// depends on swm_pkg, swm_cell and swm_select
//
// Usage:
// - slave stream carries one signed sample per transfer in tdata and the
//   restart flag in tuser; restart starts a new stream with this sample
// - master stream carries the maximum of the last window_size samples in
//   tdata; no transfer is produced until window_size samples have arrived
//   since the last restart
// - cfg_we writes window_size (reset 3); zero acts as one, above 64 as 64
// - one sample a cycle is taken unless the output stalls; each sample shifts through a chain of 64
//   compare cells, and a two-stage registered selection picks the cell that
//   matches the live window length
// - an input transfer's result passes through the sel0 register, the first selection stage and the output register
// - when the receiver stalls with a result held, the whole pipeline holds
//   and s_axis_tready drops until the result is taken
// - reset clears the counters and the output valid; cell contents are only
//   read once enough samples have passed through them

module sliding_window_maximum (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic signed [swm_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [31:0] sample
  input  logic                              s_axis_tuser,  // [0] restart
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic signed [swm_pkg::SAMPLE_W-1:0] m_axis_tdata,  // [31:0] window_max
  input  logic                              cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]         cfg_wdata
);

  logic [swm_pkg::CFG_W-1:0] window_size;
  logic [swm_pkg::CNT_W-1:0] k;
  logic [swm_pkg::CNT_W-1:0] seen, seen_base, seen_next;
  logic [swm_pkg::CNT_W-1:0] live, live_base, live_inc, live_next;
  logic                      advance, accept, emit;
  swm_pkg::swm_sel_t         sel0;
  swm_pkg::sample_t          cells [swm_pkg::WINDOW_MAX];

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;
  assign accept        = s_axis_tvalid && advance;

  always_comb begin
    k         = swm_pkg::eff_window(window_size);
    seen_base = s_axis_tuser ? '0 : seen;
    live_base = s_axis_tuser ? '0 : live;
    seen_next = (seen_base < k) ? seen_base + swm_pkg::CNT_W'(1) : seen_base;
    live_inc  = live_base + swm_pkg::CNT_W'(1);
    live_next = (live_inc > k) ? k : live_inc;
    emit      = (seen_next >= k);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      live <= '0;
    end else if (accept) begin
      seen <= seen_next;
      live <= live_next;
    end
  end

  // live length is at least one after any transfer
  always_ff @(posedge clk) begin
    if (advance) begin
      sel0.idx <= swm_pkg::IDX_W'(live_next - swm_pkg::CNT_W'(1));
    end
    if (rst) begin
      sel0.valid <= 1'b0;
    end else if (advance) begin
      sel0.valid <= accept && emit;
    end
  end

  for (genvar i = 0; i < swm_pkg::WINDOW_MAX; i++) begin : g_chain
    if (i == 0) begin : g_head
      swm_cell u_cell (
        .clk     (clk),
        .en      (accept),
        .restart (s_axis_tuser),
        .sample  (s_axis_tdata),
        .prev    (s_axis_tdata),
        .value   (cells[i])
      );
    end else begin : g_body
      swm_cell u_cell (
        .clk     (clk),
        .en      (accept),
        .restart (s_axis_tuser),
        .sample  (s_axis_tdata),
        .prev    (cells[i-1]),
        .value   (cells[i])
      );
    end
  end

  swm_select u_select (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .sel       (sel0),
    .cells     (cells),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

endmodule

@@ hdl/swm_checker.sv @@
// swm_checker: port-level assertions for sliding_window_maximum, with bind
// depends on swm_pkg and the top level's ports

module swm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic signed [swm_pkg::SAMPLE_W-1:0] s_axis_tdata,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic signed [swm_pkg::SAMPLE_W-1:0] m_axis_tdata
);

  // held result stays unchanged until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // offered sample stays unchanged until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input changed while stalled");

  // input only stalls while a result waits
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without a waiting result");

  // nothing valid right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (.*);
